// ===== src/mtp_pkg.sv =====
// ----------------------------------------------------------------------------
// mtp_pkg
// Shared types, codes and helpers for the markov transition predictor.
// ----------------------------------------------------------------------------
package mtp_pkg;

    // default sizes handed to the top level parameters
    localparam int NODE_ENTRIES_DEF = 64;
    localparam int SUCC_SLOTS_DEF   = 4;

    // field widths
    localparam int ID_W       = 32;
    localparam int CNT_W      = 32;
    localparam int FACTOR_W   = 16;
    localparam int OP_W       = 2;
    localparam int PRED_W     = 3;
    localparam int ST_W       = 2;
    localparam int KIND_W     = 2;
    localparam int PROD_W     = CNT_W + FACTOR_W;
    localparam int MAX_OUT    = 4;
    localparam int QUEUE_DEPTH = 2;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 1'd1;
    localparam logic [FACTOR_W-1:0]  FACTOR_RST = 16'd58982;

    // operation codes on the input channel
    localparam logic [OP_W-1:0] OP_ACCESS  = 2'd0;
    localparam logic [OP_W-1:0] OP_PREDICT = 2'd1;
    localparam logic [OP_W-1:0] OP_DECAY   = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

    // request classes after the front end
    localparam logic [KIND_W-1:0] KIND_ACCESS  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PREDICT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DECAY   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NOP     = 2'd3;

    // result status codes
    localparam logic [ST_W-1:0] ST_DONE = 2'd0;
    localparam logic [ST_W-1:0] ST_PRED = 2'd1;
    localparam logic [ST_W-1:0] ST_NONE = 2'd2;
    localparam logic [ST_W-1:0] ST_DROP = 2'd3;

    // previous node value meaning none
    localparam logic [ID_W-1:0] NONE_ID = '1;

    // classified request passed from front to back
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   node_id;
        logic [PRED_W-1:0] lim;
    } t_req;

    // saturating increment of a count
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ===== src/mtp_ram.sv =====
// ----------------------------------------------------------------------------
// mtp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mtp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/mtp_front.sv =====
// ----------------------------------------------------------------------------
// mtp_front
// Accepts requests, classifies the operation, clamps the prediction limit
// and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module mtp_front import mtp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [ID_W-1:0]   i_node_id,
    input  logic [PRED_W-1:0] i_max_predictions,
    input  logic              i_pop,
    output logic              o_req_valid,
    output t_req              o_req
);

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    t_req              r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    t_req              w_req;
    logic              w_push;
    logic              w_pop;

    // classify the incoming request
    always_comb begin
        w_req.node_id = i_node_id;
        w_req.lim     = (i_max_predictions > PRED_W'(MAX_OUT)) ? PRED_W'(MAX_OUT)
                                                               : i_max_predictions;
        case (i_operation)
            OP_ACCESS:  w_req.kind = KIND_ACCESS;
            OP_PREDICT: w_req.kind = KIND_PREDICT;
            OP_DECAY:   w_req.kind = KIND_DECAY;
            default:    w_req.kind = KIND_NOP;
        endcase
    end

    assign o_in_stall  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign w_push      = i_in_valid && !o_in_stall;
    assign o_req_valid = (r_count != '0);
    assign w_pop       = i_pop && o_req_valid;
    assign o_req       = r_q[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_req;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!w_push && w_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== src/mtp_back.sv =====
// ----------------------------------------------------------------------------
// mtp_back
// Sequencer that carries out requests: node table scan, successor update,
// ranked successor readout and the decay sweep, plus the result register.
// ----------------------------------------------------------------------------
module mtp_back import mtp_pkg::*; #(
    parameter int NODE_ENTRIES = NODE_ENTRIES_DEF,
    parameter int SUCC_SLOTS   = SUCC_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_learn,
    input  logic [FACTOR_W-1:0] i_factor,
    input  logic                i_req_valid,
    input  t_req                i_req,
    output logic                o_pop,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [ST_W-1:0]     o_status,
    output logic [ID_W-1:0]     o_predicted_node,
    output logic                o_last
);

    localparam int IW     = $clog2(NODE_ENTRIES);
    localparam int CW     = $clog2(NODE_ENTRIES + 1);
    localparam int SIW    = (SUCC_SLOTS > 1) ? $clog2(SUCC_SLOTS) : 1;
    localparam int SJW    = $clog2(SUCC_SLOTS + 1);
    localparam int NODE_W = ID_W + CNT_W;
    localparam int SLOT_W = ID_W + CNT_W;
    localparam int ROW_W  = SUCC_SLOTS * SLOT_W;
    localparam int CMP_W  = 8;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN     = 4'd1;
    localparam logic [3:0] S_LOOKED   = 4'd2;
    localparam logic [3:0] S_ROW_WAIT = 4'd3;
    localparam logic [3:0] S_PICK     = 4'd4;
    localparam logic [3:0] S_EMIT     = 4'd5;
    localparam logic [3:0] S_DEC_RD   = 4'd6;
    localparam logic [3:0] S_DEC_LD   = 4'd7;
    localparam logic [3:0] S_DEC_MUL  = 4'd8;
    localparam logic [3:0] S_DEC_WB   = 4'd9;
    localparam logic [3:0] S_DEC_WR   = 4'd10;

    logic [3:0]            r_state;
    logic [KIND_W-1:0]     r_kind;
    logic [ID_W-1:0]       r_id;
    logic [PRED_W-1:0]     r_lim;
    logic [ID_W-1:0]       r_prev;
    logic                  r_phase;
    logic [ID_W-1:0]       r_key;
    logic [CW-1:0]         r_issue;
    logic                  r_cmp_v;
    logic [IW-1:0]         r_cmp_idx;
    logic                  r_hit;
    logic [IW-1:0]         r_found_idx;
    logic                  r_free_found;
    logic [IW-1:0]         r_free_idx;
    logic [CNT_W-1:0]      r_hits;
    logic [ID_W-1:0]       r_tag;
    logic                  r_dropped;
    logic [IW-1:0]         r_row_idx;
    logic [NODE_ENTRIES-1:0] r_node_valid;
    logic [SUCC_SLOTS-1:0] r_succ_valid [NODE_ENTRIES];
    logic [ID_W-1:0]       r_tgt [SUCC_SLOTS];
    logic [CNT_W-1:0]      r_cnt [SUCC_SLOTS];
    logic [SUCC_SLOTS-1:0] r_used;
    logic [PRED_W-1:0]     r_total;
    logic [PRED_W-1:0]     r_k;
    logic [SJW-1:0]        r_j;
    logic                  r_best_v;
    logic [SIW-1:0]        r_best_j;
    logic [CNT_W-1:0]      r_best_cnt;
    logic [ID_W-1:0]       r_best_tgt;
    logic [PROD_W-1:0]     r_prod;
    logic [CW-1:0]         r_dec_idx;
    logic [ST_W-1:0]       r_res_status;
    logic [ID_W-1:0]       r_res_node;
    logic                  r_res_last;
    logic                  r_res_more;
    logic                  r_out_valid;
    logic [ST_W-1:0]       r_out_status;
    logic [ID_W-1:0]       r_out_node;
    logic                  r_out_last;

    logic                  w_node_we;
    logic [IW-1:0]         w_node_waddr;
    logic [NODE_W-1:0]     w_node_wdata;
    logic [IW-1:0]         w_node_raddr;
    logic [NODE_W-1:0]     w_node_rdata;
    logic                  w_succ_we;
    logic [IW-1:0]         w_succ_waddr;
    logic [ROW_W-1:0]      w_succ_wdata;
    logic [IW-1:0]         w_succ_raddr;
    logic [ROW_W-1:0]      w_succ_rdata;

    logic [ID_W-1:0]       w_rd_tag;
    logic [CNT_W-1:0]      w_rd_hits;
    logic [IW-1:0]         w_issue_idx;
    logic                  w_issue_ok;
    logic                  w_cmp_match;
    logic [IW-1:0]         w_sel_idx;
    logic                  w_sel_ok;
    logic                  w_out_free;
    logic [ID_W-1:0]       w_rd_tgt [SUCC_SLOTS];
    logic [CNT_W-1:0]      w_rd_cnt [SUCC_SLOTS];
    logic [SUCC_SLOTS-1:0] w_vrow;
    logic [SUCC_SLOTS-1:0] w_match;
    logic                  w_any_match;
    logic                  w_free_ok;
    logic [SIW-1:0]        w_free_j;
    logic                  w_bump_ok;
    logic [ROW_W-1:0]      w_bump_row;
    logic [ROW_W-1:0]      w_dec_row;
    logic [SJW-1:0]        w_pop_cnt;
    logic [PRED_W-1:0]     w_total;
    logic [SIW-1:0]        w_cj;
    logic                  w_cand;
    logic                  w_better;
    logic [SIW-1:0]        w_nb_j;
    logic [ID_W-1:0]       w_nb_tgt;
    logic [CNT_W-1:0]      w_mul_in;
    logic [CNT_W-1:0]      w_scaled;
    logic                  w_pick_last;

    // node table: tag and access count
    mtp_ram #(
        .WIDTH(NODE_W),
        .DEPTH(NODE_ENTRIES)
    ) u_node_ram (
        .i_clk  (i_clk),
        .i_we   (w_node_we),
        .i_waddr(w_node_waddr),
        .i_wdata(w_node_wdata),
        .i_raddr(w_node_raddr),
        .o_rdata(w_node_rdata)
    );

    // successor rows: one row of slots per node
    mtp_ram #(
        .WIDTH(ROW_W),
        .DEPTH(NODE_ENTRIES)
    ) u_succ_ram (
        .i_clk  (i_clk),
        .i_we   (w_succ_we),
        .i_waddr(w_succ_waddr),
        .i_wdata(w_succ_wdata),
        .i_raddr(w_succ_raddr),
        .o_rdata(w_succ_rdata)
    );

    // node scan compare
    assign w_rd_tag    = w_node_rdata[NODE_W-1:CNT_W];
    assign w_rd_hits   = w_node_rdata[CNT_W-1:0];
    assign w_issue_idx = r_issue[IW-1:0];
    assign w_issue_ok  = (r_issue < CW'(NODE_ENTRIES));
    assign w_cmp_match = r_cmp_v && r_node_valid[r_cmp_idx] && (w_rd_tag == r_key);
    assign w_sel_idx   = r_hit ? r_found_idx : r_free_idx;
    assign w_sel_ok    = r_hit || r_free_found;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_pop       = (r_state == S_IDLE) && i_req_valid;

    // successor row unpack, transition bump, decay row pack and popcount
    always_comb begin
        w_vrow      = r_succ_valid[r_row_idx];
        w_free_ok   = 1'b0;
        w_free_j    = '0;
        w_pop_cnt   = '0;
        for (int j = 0; j < SUCC_SLOTS; j++) begin
            w_rd_tgt[j] = w_succ_rdata[j*SLOT_W +: ID_W];
            w_rd_cnt[j] = w_succ_rdata[j*SLOT_W+ID_W +: CNT_W];
            w_match[j]  = w_vrow[j] && (w_rd_tgt[j] == r_id);
            w_pop_cnt   = w_pop_cnt + SJW'(w_vrow[j]);
            if (!w_vrow[j] && !w_free_ok) begin
                w_free_ok = 1'b1;
                w_free_j  = SIW'(j);
            end
        end
        w_any_match = |w_match;
        w_bump_ok   = w_any_match || w_free_ok;
        for (int j = 0; j < SUCC_SLOTS; j++) begin
            w_bump_row[j*SLOT_W +: ID_W]       = w_rd_tgt[j];
            w_bump_row[j*SLOT_W+ID_W +: CNT_W] = w_match[j] ? sat_inc(w_rd_cnt[j])
                                                            : w_rd_cnt[j];
            if (!w_any_match && w_free_ok && (w_free_j == SIW'(j))) begin
                w_bump_row[j*SLOT_W +: ID_W]       = r_id;
                w_bump_row[j*SLOT_W+ID_W +: CNT_W] = CNT_W'(1);
            end
            w_dec_row[j*SLOT_W +: ID_W]       = r_tgt[j];
            w_dec_row[j*SLOT_W+ID_W +: CNT_W] = r_cnt[j];
        end
        w_total = (CMP_W'(w_pop_cnt) < CMP_W'(r_lim)) ? PRED_W'(w_pop_cnt) : r_lim;
    end

    // ranked pick: running best over the slots
    assign w_cj        = r_j[SIW-1:0];
    assign w_cand      = r_succ_valid[r_row_idx][w_cj] && !r_used[w_cj];
    assign w_better    = w_cand && (!r_best_v ||
                         ({r_cnt[w_cj], r_tgt[w_cj]} > {r_best_cnt, r_best_tgt}));
    assign w_nb_j      = w_better ? w_cj : r_best_j;
    assign w_nb_tgt    = w_better ? r_tgt[w_cj] : r_best_tgt;
    assign w_pick_last = ((r_k + PRED_W'(1)) == r_total);

    // decay multiply operand and scaled result
    assign w_mul_in = (r_j == SJW'(SUCC_SLOTS)) ? r_hits : r_cnt[r_j[SIW-1:0]];
    assign w_scaled = r_prod[PROD_W-1:FACTOR_W];

    // memory port control
    always_comb begin
        w_node_raddr = (r_state == S_SCAN) ? w_issue_idx : r_dec_idx[IW-1:0];
        w_succ_raddr = (r_state == S_DEC_RD) ? r_dec_idx[IW-1:0] : w_sel_idx;
        w_node_we    = 1'b0;
        w_node_waddr = w_sel_idx;
        w_node_wdata = {r_id, CNT_W'(1)};
        w_succ_we    = 1'b0;
        w_succ_waddr = r_row_idx;
        w_succ_wdata = w_bump_row;
        case (r_state)
            S_LOOKED: begin
                if ((r_kind == KIND_ACCESS) && w_sel_ok) begin
                    if (!r_phase) begin
                        w_node_we    = 1'b1;
                        w_node_wdata = {r_id, r_hit ? sat_inc(r_hits) : CNT_W'(1)};
                    end else if (!r_hit) begin
                        w_node_we    = 1'b1;
                        w_node_wdata = {r_prev, CNT_W'(0)};
                    end
                end
            end
            S_ROW_WAIT: begin
                w_succ_we = (r_kind == KIND_ACCESS) && w_bump_ok;
            end
            S_DEC_WR: begin
                w_node_we    = 1'b1;
                w_node_waddr = r_row_idx;
                w_node_wdata = {r_tag, r_hits};
                w_succ_we    = 1'b1;
                w_succ_wdata = w_dec_row;
            end
            default: begin
                w_node_we = 1'b0;
            end
        endcase
    end

    // request sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prev       <= NONE_ID;
            r_node_valid <= '0;
            for (int i = 0; i < NODE_ENTRIES; i++) begin
                r_succ_valid[i] <= '0;
            end
            r_cmp_v      <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_phase      <= 1'b0;
            r_dropped    <= 1'b0;
            r_res_more   <= 1'b0;
            r_best_v     <= 1'b0;
        end else begin
            case (r_state)
                // take the next queued request
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_kind       <= i_req.kind;
                        r_id         <= i_req.node_id;
                        r_lim        <= i_req.lim;
                        r_dropped    <= 1'b0;
                        r_phase      <= 1'b0;
                        r_key        <= i_req.node_id;
                        r_issue      <= '0;
                        r_cmp_v      <= 1'b0;
                        r_hit        <= 1'b0;
                        r_free_found <= 1'b0;
                        r_res_node   <= '0;
                        r_res_last   <= 1'b1;
                        r_res_more   <= 1'b0;
                        r_res_status <= ST_DONE;
                        r_dec_idx    <= '0;
                        case (i_req.kind)
                            KIND_ACCESS:  r_state <= i_learn ? S_SCAN : S_EMIT;
                            KIND_PREDICT: begin
                                if (i_req.lim == '0) begin
                                    r_res_status <= ST_NONE;
                                    r_state      <= S_EMIT;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            KIND_DECAY:   r_state <= S_DEC_RD;
                            default:      r_state <= S_EMIT;
                        endcase
                    end
                end

                // pipelined tag scan, one entry per cycle
                S_SCAN: begin
                    if (w_cmp_match) begin
                        r_hit       <= 1'b1;
                        r_found_idx <= r_cmp_idx;
                        r_hits      <= w_rd_hits;
                        r_state     <= S_LOOKED;
                    end else if (!w_issue_ok && !r_cmp_v) begin
                        r_state <= S_LOOKED;
                    end else if (w_issue_ok) begin
                        r_issue   <= r_issue + CW'(1);
                        r_cmp_v   <= 1'b1;
                        r_cmp_idx <= w_issue_idx;
                        if (!r_free_found && !r_node_valid[w_issue_idx]) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= w_issue_idx;
                        end
                    end else begin
                        r_cmp_v <= 1'b0;
                    end
                end

                // act on the scan result
                S_LOOKED: begin
                    if (r_kind == KIND_PREDICT) begin
                        if (r_hit) begin
                            r_row_idx <= r_found_idx;
                            r_state   <= S_ROW_WAIT;
                        end else begin
                            r_res_status <= ST_NONE;
                            r_state      <= S_EMIT;
                        end
                    end else begin
                        if (!r_hit && r_free_found) begin
                            r_node_valid[r_free_idx] <= 1'b1;
                            r_succ_valid[r_free_idx] <= '0;
                        end
                        if (!r_phase) begin
                            if ((r_prev != NONE_ID) && (r_prev != r_id)) begin
                                r_dropped    <= !w_sel_ok;
                                r_phase      <= 1'b1;
                                r_key        <= r_prev;
                                r_issue      <= '0;
                                r_cmp_v      <= 1'b0;
                                r_hit        <= 1'b0;
                                r_free_found <= 1'b0;
                                r_state      <= S_SCAN;
                            end else begin
                                r_prev       <= r_id;
                                r_res_status <= w_sel_ok ? ST_DONE : ST_DROP;
                                r_state      <= S_EMIT;
                            end
                        end else if (w_sel_ok) begin
                            r_row_idx <= w_sel_idx;
                            r_state   <= S_ROW_WAIT;
                        end else begin
                            r_prev       <= r_id;
                            r_res_status <= ST_DROP;
                            r_state      <= S_EMIT;
                        end
                    end
                end

                // successor row is on the read port
                S_ROW_WAIT: begin
                    if (r_kind == KIND_ACCESS) begin
                        if (!w_any_match && w_free_ok) begin
                            r_succ_valid[r_row_idx][w_free_j] <= 1'b1;
                        end
                        r_prev       <= r_id;
                        r_res_status <= (r_dropped || !w_bump_ok) ? ST_DROP : ST_DONE;
                        r_state      <= S_EMIT;
                    end else begin
                        for (int j = 0; j < SUCC_SLOTS; j++) begin
                            r_tgt[j] <= w_rd_tgt[j];
                            r_cnt[j] <= w_rd_cnt[j];
                        end
                        r_used   <= '0;
                        r_total  <= w_total;
                        r_k      <= '0;
                        r_j      <= '0;
                        r_best_v <= 1'b0;
                        if (w_total == '0) begin
                            r_res_status <= ST_NONE;
                            r_state      <= S_EMIT;
                        end else begin
                            r_state <= S_PICK;
                        end
                    end
                end

                // walk the slots for the next best successor
                S_PICK: begin
                    if (r_j == SJW'(SUCC_SLOTS - 1)) begin
                        r_used[w_nb_j] <= 1'b1;
                        r_k            <= r_k + PRED_W'(1);
                        r_res_status   <= ST_PRED;
                        r_res_node     <= w_nb_tgt;
                        r_res_last     <= w_pick_last;
                        r_res_more     <= !w_pick_last;
                        r_j            <= '0;
                        r_best_v       <= 1'b0;
                        r_state        <= S_EMIT;
                    end else begin
                        if (w_better) begin
                            r_best_v   <= 1'b1;
                            r_best_j   <= w_cj;
                            r_best_cnt <= r_cnt[w_cj];
                            r_best_tgt <= r_tgt[w_cj];
                        end
                        r_j <= r_j + SJW'(1);
                    end
                end

                // hand a result to the output register
                S_EMIT: begin
                    if (w_out_free) begin
                        r_state <= r_res_more ? S_PICK : S_IDLE;
                    end
                end

                // decay sweep: next live node
                S_DEC_RD: begin
                    if (r_dec_idx == CW'(NODE_ENTRIES)) begin
                        r_res_status <= ST_DONE;
                        r_state      <= S_EMIT;
                    end else if (!r_node_valid[r_dec_idx[IW-1:0]]) begin
                        r_dec_idx <= r_dec_idx + CW'(1);
                    end else begin
                        r_row_idx <= r_dec_idx[IW-1:0];
                        r_state   <= S_DEC_LD;
                    end
                end

                S_DEC_LD: begin
                    r_tag  <= w_rd_tag;
                    r_hits <= w_rd_hits;
                    for (int j = 0; j < SUCC_SLOTS; j++) begin
                        r_tgt[j] <= w_rd_tgt[j];
                        r_cnt[j] <= w_rd_cnt[j];
                    end
                    r_j     <= '0;
                    r_state <= S_DEC_MUL;
                end

                // one shared multiply per count
                S_DEC_MUL: begin
                    r_prod  <= PROD_W'(w_mul_in) * PROD_W'(i_factor);
                    r_state <= S_DEC_WB;
                end

                S_DEC_WB: begin
                    if (r_j == SJW'(SUCC_SLOTS)) begin
                        r_hits  <= w_scaled;
                        r_state <= S_DEC_WR;
                    end else begin
                        r_cnt[r_j[SIW-1:0]] <= w_scaled;
                        if (w_scaled == '0) begin
                            r_succ_valid[r_row_idx][r_j[SIW-1:0]] <= 1'b0;
                        end
                        r_j     <= r_j + SJW'(1);
                        r_state <= S_DEC_MUL;
                    end
                end

                // write back and drop an empty node
                S_DEC_WR: begin
                    if ((r_hits == '0) && (r_succ_valid[r_row_idx] == '0)) begin
                        r_node_valid[r_row_idx] <= 1'b0;
                    end
                    r_dec_idx <= r_dec_idx + CW'(1);
                    r_state   <= S_DEC_RD;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_EMIT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && w_out_free) begin
            r_out_status <= r_res_status;
            r_out_node   <= r_res_node;
            r_out_last   <= r_res_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_predicted_node = r_out_node;
    assign o_last           = r_out_last;

endmodule

// ===== src/markov_transition_predictor_unit.sv =====
// ----------------------------------------------------------------------------
// markov_transition_predictor_unit
// Node transition table with access counting, ranked successor prediction
// and multiplicative decay.
// ----------------------------------------------------------------------------
// The node table scan reads one entry of the node RAM per cycle. An access
// with learning on scans the table for its node and, when the previous node
// differs, scans again for the previous node and bumps its transition. A
// predict scans for its node and then walks the successor slots once per
// returned successor. A decay walks every entry, skipping empty ones, and
// scales the counts of each live node through the single shared 32x16
// multiplier. Results leave through an output register, and a two-entry
// request queue lets new requests be taken while the back end is busy.
// ----------------------------------------------------------------------------
module markov_transition_predictor_unit import mtp_pkg::*; #(
    parameter int NODE_ENTRIES = NODE_ENTRIES_DEF,
    parameter int SUCC_SLOTS   = SUCC_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [ID_W-1:0]       i_node_id,
    input  logic [PRED_W-1:0]     i_max_predictions,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [ST_W-1:0]       o_status,
    output logic [ID_W-1:0]       o_predicted_node,
    output logic                  o_last,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                r_learn;
    logic [FACTOR_W-1:0] r_factor;
    logic                w_req_valid;
    t_req                w_req;
    logic                w_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn  <= 1'b1;
            r_factor <= FACTOR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LEARN:  r_learn  <= i_cfg_data[0];
                CFG_FACTOR: r_factor <= i_cfg_data[FACTOR_W-1:0];
                default:    r_learn  <= r_learn;
            endcase
        end
    end

    // request intake and queue
    mtp_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_node_id        (i_node_id),
        .i_max_predictions(i_max_predictions),
        .i_pop            (w_pop),
        .o_req_valid      (w_req_valid),
        .o_req            (w_req)
    );

    // table engine and result register
    mtp_back #(
        .NODE_ENTRIES(NODE_ENTRIES),
        .SUCC_SLOTS  (SUCC_SLOTS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_learn         (r_learn),
        .i_factor        (r_factor),
        .i_req_valid     (w_req_valid),
        .i_req           (w_req),
        .o_pop           (w_pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_predicted_node(o_predicted_node),
        .o_last          (o_last)
    );

endmodule
